>>> hw/rtl/bit_sliced_hamming_encoder_macros.svh
// Assertion macros shared by the encoder RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef BIT_SLICED_HAMMING_ENCODER_MACROS_SVH
`define BIT_SLICED_HAMMING_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BSHE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bshe assertion failed");

// Next-cycle implication, disabled while reset is held.
`define BSHE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bshe assertion failed");

`endif

>>> hw/rtl/bshe_pkg.sv
// Shared widths, request codes, read-decode struct and helpers for the
// byte-interleaved Hamming encoder. No dependencies.
package bshe_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 11;  // counts, positions, lengths
    localparam int POS_W  = 12;  // 1-based position of a read, one bit wider
    localparam int LG_W   = 4;   // log2 of a position

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Decode of one read request against the current message.
    typedef struct packed {
        logic [LEN_W-1:0] len;     // codeword length
        logic             bad;     // read_pos >= len
        logic             is_par;  // position is a power of two
        logic             par_ok;  // parity slot exists for this position
        logic [LG_W-1:0]  lg;      // parity slot index
        logic [LEN_W-1:0] idx;     // data store index
        logic             idx_ok;  // data store entry holds this position
    } t_rd_info;

    function automatic logic is_pow2(input logic [POS_W-1:0] v);
        return (v != '0) && ((v & (v - POS_W'(1))) == '0);
    endfunction

    function automatic logic [LG_W-1:0] floor_log2(input logic [POS_W-1:0] v);
        logic [LG_W-1:0] r;
        r = '0;
        for (int i = 0; i < POS_W; i++) begin
            if (v[i]) begin
                r = LG_W'(i);
            end
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/bit_sliced_hamming_encoder.sv
// Top level of the byte-interleaved Hamming encoder: data store, parity
// accumulators, result register. Uses bshe_pkg, bshe_locate and the macro header.
//
// Load beats (req_type 0) append one data byte to the current message; a load
// with first_byte set starts a new message. Each load is written into the data
// store and folded into the parity bytes of every slot whose bit is set in the
// byte's codeword position. Read beats (req_type 1) return the codeword byte at
// read_pos with the codeword length, an out-of-range flag and the sticky
// overflow flag. The block takes one beat per cycle unless a read beat is
// stalled: a load finishes at its accept edge, and a read's result appears in
// the output register in the cycle after acceptance, set by the registered read
// of the data store. While a result is held by output stall, read beats are
// stalled and load beats are still taken. No clearing pass is needed after
// reset: reads only reach data entries written in the current message.
`include "bit_sliced_hamming_encoder_macros.svh"

module bit_sliced_hamming_encoder #(
    parameter int MAX_DATA     = 1024,
    parameter int PARITY_SLOTS = 11
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_in_req_type,
    input  logic [bshe_pkg::BYTE_W-1:0] i_in_data_byte,
    input  logic                        i_in_first_byte,
    input  logic [bshe_pkg::LEN_W-1:0]  i_in_read_pos,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bshe_pkg::BYTE_W-1:0] o_out_code_byte,
    output logic [bshe_pkg::LEN_W-1:0]  o_out_code_len,
    output logic                        o_out_bad_pos,
    output logic                        o_out_overflowed
);

    localparam int AW         = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
    localparam int PS_W       = $clog2(PARITY_SLOTS);
    // largest message that the parity slots can protect
    localparam int SLOT_LIMIT = (1 << PARITY_SLOTS) - PARITY_SLOTS - 1;
    localparam int CAPACITY   = (SLOT_LIMIT < MAX_DATA) ? SLOT_LIMIT : MAX_DATA;
    localparam logic [bshe_pkg::LEN_W-1:0] CAP_L = bshe_pkg::LEN_W'(CAPACITY);
    localparam logic [bshe_pkg::LEN_W-1:0] POS_START = bshe_pkg::LEN_W'(3);

    // message state
    logic [bshe_pkg::BYTE_W-1:0] r_acc [PARITY_SLOTS];
    logic [bshe_pkg::BYTE_W-1:0] n_acc [PARITY_SLOTS];
    logic [bshe_pkg::LEN_W-1:0]  r_count, n_count;
    logic [bshe_pkg::LEN_W-1:0]  r_next_pos, n_next_pos;
    logic                        r_ovf, n_ovf;

    // data store, one entry per data byte
    logic [bshe_pkg::BYTE_W-1:0] r_data_mem [MAX_DATA];
    logic [bshe_pkg::BYTE_W-1:0] r_mem_q;

    // result register
    logic                        r_out_valid;
    logic [bshe_pkg::LEN_W-1:0]  r_len;
    logic                        r_bad;
    logic                        r_ovf_out;
    logic                        r_use_mem;
    logic [bshe_pkg::BYTE_W-1:0] r_par_val;

    logic                        fire, load_fire, read_fire;
    logic                        full, wr_en;
    logic [AW-1:0]               wr_addr;
    logic [bshe_pkg::LEN_W-1:0]  base_count, base_pos, pos_inc;
    logic                        base_ovf;
    logic [bshe_pkg::BYTE_W-1:0] par_sel;
    bshe_pkg::t_rd_info          rd_info;

    // a held result blocks reads only
    assign o_in_stall = r_out_valid && i_out_stall && (i_in_req_type == bshe_pkg::REQ_READ);
    assign fire       = i_in_valid && !o_in_stall;
    assign load_fire  = fire && (i_in_req_type == bshe_pkg::REQ_LOAD);
    assign read_fire  = fire && (i_in_req_type == bshe_pkg::REQ_READ);

    // ---------------- load path ----------------
    // first_byte restarts the message before the byte itself is stored
    assign base_count = i_in_first_byte ? '0 : r_count;
    assign base_pos   = i_in_first_byte ? POS_START : r_next_pos;
    assign base_ovf   = i_in_first_byte ? 1'b0 : r_ovf;
    assign full       = (base_count >= CAP_L);
    assign pos_inc    = base_pos + bshe_pkg::LEN_W'(1);
    assign wr_en      = load_fire && !full;
    assign wr_addr    = base_count[AW-1:0];

    always_comb begin
        for (int k = 0; k < PARITY_SLOTS; k++) begin
            n_acc[k] = i_in_first_byte ? '0 : r_acc[k];
            if (!full && base_pos[k]) begin
                n_acc[k] = n_acc[k] ^ i_in_data_byte;
            end
        end
        if (full) begin
            // dropped byte: only the sticky flag moves
            n_count    = base_count;
            n_next_pos = base_pos;
            n_ovf      = 1'b1;
        end else begin
            n_count    = base_count + bshe_pkg::LEN_W'(1);
            // skip the parity positions
            n_next_pos = bshe_pkg::is_pow2({1'b0, pos_inc})
                         ? pos_inc + bshe_pkg::LEN_W'(1) : pos_inc;
            n_ovf      = base_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PARITY_SLOTS; k++) begin
                r_acc[k] <= '0;
            end
            r_count    <= '0;
            r_next_pos <= POS_START;
            r_ovf      <= 1'b0;
        end else if (load_fire) begin
            for (int k = 0; k < PARITY_SLOTS; k++) begin
                r_acc[k] <= n_acc[k];
            end
            r_count    <= n_count;
            r_next_pos <= n_next_pos;
            r_ovf      <= n_ovf;
        end
    end

    // ---------------- read path ----------------
    bshe_locate #(
        .MAX_DATA     (MAX_DATA),
        .PARITY_SLOTS (PARITY_SLOTS)
    ) u_locate (
        .i_count    (r_count),
        .i_read_pos (i_in_read_pos),
        .o_info     (rd_info)
    );

    assign par_sel = rd_info.par_ok ? r_acc[rd_info.lg[PS_W-1:0]] : '0;

    // store: write on a kept load, registered read on a read beat;
    // the two never share a cycle, so no forwarding is needed
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_data_mem[wr_addr] <= i_in_data_byte;
        end
        if (read_fire) begin
            r_mem_q <= r_data_mem[rd_info.idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (read_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (read_fire) begin
            r_len     <= rd_info.len;
            r_bad     <= rd_info.bad;
            r_ovf_out <= r_ovf;
            r_use_mem <= rd_info.idx_ok && !rd_info.is_par;
            r_par_val <= par_sel;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_code_byte  = r_use_mem ? r_mem_q : r_par_val;
    assign o_out_code_len   = r_len;
    assign o_out_bad_pos    = r_bad;
    assign o_out_overflowed = r_ovf_out;

    // ---------------- checks ----------------
    `BSHE_ASSERT_IMP(a_bad_is_zero, i_clk, i_rst_n, r_out_valid && r_bad, o_out_code_byte == '0)
    `BSHE_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CAP_L)
    `BSHE_ASSERT_IMP(a_pos_not_parity, i_clk, i_rst_n, 1'b1,
                     !bshe_pkg::is_pow2({1'b0, r_next_pos}))
    `BSHE_ASSERT_NXT(a_first_restarts, i_clk, i_rst_n, load_fire && i_in_first_byte,
                     (r_count == bshe_pkg::LEN_W'(1)) && !r_ovf)

endmodule

>>> hw/rtl/bshe_locate.sv
// Read-request decoder: parity count, codeword length and the source
// (parity slot or data store entry) of one codeword byte. Uses bshe_pkg.
module bshe_locate #(
    parameter int MAX_DATA     = 1024,
    parameter int PARITY_SLOTS = 11
) (
    input  logic [bshe_pkg::LEN_W-1:0] i_count,
    input  logic [bshe_pkg::LEN_W-1:0] i_read_pos,
    output bshe_pkg::t_rd_info         o_info
);

    localparam logic [bshe_pkg::LEN_W-1:0] MAX_L = bshe_pkg::LEN_W'(MAX_DATA);

    logic [bshe_pkg::LG_W-1:0]  p;
    logic                       found;
    logic [bshe_pkg::POS_W-1:0] count_w;
    logic [bshe_pkg::POS_W-1:0] len_w;
    logic [bshe_pkg::POS_W-1:0] pos;

    assign count_w = {1'b0, i_count};

    // smallest p >= 2 with p + n < 2^p, capped at the slot count
    always_comb begin
        p     = bshe_pkg::LG_W'(2);
        found = 1'b0;
        for (int k = 2; k < PARITY_SLOTS; k++) begin
            if (!found) begin
                if ((count_w + bshe_pkg::POS_W'(k)) >= bshe_pkg::POS_W'(1 << k)) begin
                    p = bshe_pkg::LG_W'(k + 1);
                end else begin
                    found = 1'b1;
                end
            end
        end
    end

    assign len_w = count_w + bshe_pkg::POS_W'(p);
    assign pos   = {1'b0, i_read_pos} + bshe_pkg::POS_W'(1);

    always_comb begin
        o_info.len    = len_w[bshe_pkg::LEN_W-1:0];
        o_info.bad    = (i_read_pos >= o_info.len);
        o_info.is_par = bshe_pkg::is_pow2(pos);
        o_info.lg     = bshe_pkg::floor_log2(pos);
        o_info.par_ok = !o_info.bad && o_info.is_par && (o_info.lg < p)
                        && (o_info.lg < bshe_pkg::LG_W'(PARITY_SLOTS));
        // data index = position - 1 - (number of parity slots below it)
        o_info.idx    = i_read_pos - bshe_pkg::LEN_W'(o_info.lg) - bshe_pkg::LEN_W'(1);
        o_info.idx_ok = !o_info.bad && !o_info.is_par && (o_info.idx < i_count)
                        && (o_info.idx < MAX_L);
    end

endmodule

>>> verif/tb.sv
// Testbench for bit_sliced_hamming_encoder: directed table, then random messages,
// checked against an in-bench codeword predictor. Depends on bshe_pkg and the RTL.
`timescale 1ns / 100ps

module tb;

    localparam int MAX_DATA     = 1024;
    localparam int PARITY_SLOTS = 11;
    // largest message: store depth or what the parity slots can protect
    localparam int SLOT_LIMIT   = (1 << PARITY_SLOTS) - PARITY_SLOTS - 1;
    localparam int CODE_CAP     = (SLOT_LIMIT < MAX_DATA) ? SLOT_LIMIT : MAX_DATA;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_CYCLES = 300;

    // one request beat, plus an optional typed-in result for directed rows
    typedef struct packed {
        logic                        req;
        logic [bshe_pkg::BYTE_W-1:0] data;
        logic                        first;
        logic [bshe_pkg::LEN_W-1:0]  pos;
        logic                        chk;
        logic [bshe_pkg::BYTE_W-1:0] e_code;
        logic [bshe_pkg::LEN_W-1:0]  e_len;
        logic                        e_bad;
        logic                        e_ovf;
    } t_beat;

    typedef struct packed {
        logic [bshe_pkg::BYTE_W-1:0] code;
        logic [bshe_pkg::LEN_W-1:0]  len;
        logic                        bad;
        logic                        ovf;
    } t_code_rd;

    // Directed rows. Typed results only for the empty message after reset and
    // for out-of-range reads; the rest go through the predictor.
    localparam int DIR_N = 23;
    localparam t_beat DIR_TAB [DIR_N] = '{
        // empty message: two zero parity bytes
        '{bshe_pkg::REQ_READ, 8'h00, 1'b0, 11'd0,    1'b1, 8'h00, 11'd2, 1'b0, 1'b0},
        '{bshe_pkg::REQ_READ, 8'hFF, 1'b1, 11'd1,    1'b1, 8'h00, 11'd2, 1'b0, 1'b0},
        '{bshe_pkg::REQ_READ, 8'h00, 1'b0, 11'd2,    1'b1, 8'h00, 11'd2, 1'b1, 1'b0},
        '{bshe_pkg::REQ_READ, 8'hFF, 1'b1, 11'd2047, 1'b1, 8'h00, 11'd2, 1'b1, 1'b0},
        // four-byte message, extremes of the data byte
        '{bshe_pkg::REQ_LOAD, 8'hFF, 1'b1, 11'd2047, 1'b0, 8'h00, 11'd0, 1'b0, 1'b0},
        '{bshe_pkg::REQ_LOAD, 8'h00, 1'b0, 11'd0,    1'b0, 8'h00, 11'd0, 1'b0, 1'b0},
        '{bshe_pkg::REQ_LOAD, 8'hA5, 1'b0, 11'd1365, 1'b0, 8'h00, 11'd0, 1'b0, 1'b0},
        '{bshe_pkg::REQ_LOAD, 8'h5A, 1'b0, 11'd682,  1'b0, 8'h00, 11'd0, 1'b0, 1'b0},
        '{bshe_pkg::REQ_READ, 8'h00, 1'b0, 11'd0,    1'b0, 8'h00, 11'd0, 1'b0, 1'b0},
        '{bshe_pkg::REQ_READ, 8'h00, 1'b0, 11'd1,    1'b0, 8'h00, 11'd0, 1'b0, 1'b0},
        '{bshe_pkg::REQ_READ, 8'h00, 1'b0, 11'd2,    1'b0, 8'h00, 11'd0, 1'b0, 1'b0},
        '{bshe_pkg::REQ_READ, 8'h00, 1'b0, 11'd3,    1'b0, 8'h00, 11'd0, 1'b0, 1'b0},
        '{bshe_pkg::REQ_READ, 8'h00, 1'b0, 11'd4,    1'b0, 8'h00, 11'd0, 1'b0, 1'b0},
        '{bshe_pkg::REQ_READ, 8'h00, 1'b0, 11'd5,    1'b0, 8'h00, 11'd0, 1'b0, 1'b0},
        '{bshe_pkg::REQ_READ, 8'h00, 1'b0, 11'd6,    1'b0, 8'h00, 11'd0, 1'b0, 1'b0},
        '{bshe_pkg::REQ_READ, 8'h00, 1'b0, 11'd7,    1'b1, 8'h00, 11'd7, 1'b1, 1'b0},
        // new message of one byte
        '{bshe_pkg::REQ_LOAD, 8'h80, 1'b1, 11'd0,    1'b0, 8'h00, 11'd0, 1'b0, 1'b0},
        '{bshe_pkg::REQ_READ, 8'h00, 1'b0, 11'd0,    1'b0, 8'h00, 11'd0, 1'b0, 1'b0},
        '{bshe_pkg::REQ_READ, 8'h00, 1'b0, 11'd2,    1'b0, 8'h00, 11'd0, 1'b0, 1'b0},
        '{bshe_pkg::REQ_READ, 8'h00, 1'b0, 11'd3,    1'b1, 8'h00, 11'd3, 1'b1, 1'b0},
        // append without first_byte: parity count grows to three
        '{bshe_pkg::REQ_LOAD, 8'h01, 1'b0, 11'd0,    1'b0, 8'h00, 11'd0, 1'b0, 1'b0},
        '{bshe_pkg::REQ_READ, 8'h00, 1'b0, 11'd4,    1'b0, 8'h00, 11'd0, 1'b0, 1'b0},
        '{bshe_pkg::REQ_READ, 8'h00, 1'b0, 11'd5,    1'b1, 8'h00, 11'd5, 1'b1, 1'b0}
    };

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic                        i_in_req_type;
    logic [bshe_pkg::BYTE_W-1:0] i_in_data_byte;
    logic                        i_in_first_byte;
    logic [bshe_pkg::LEN_W-1:0]  i_in_read_pos;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic [bshe_pkg::BYTE_W-1:0] o_out_code_byte;
    logic [bshe_pkg::LEN_W-1:0]  o_out_code_len;
    logic                        o_out_bad_pos;
    logic                        o_out_overflowed;

    // typed-in result travelling with the beat on the bus
    logic              cur_chk;
    t_code_rd          cur_typed;

    t_beat    stim [$];
    t_code_rd pending_reads [$];

    // predictor state
    logic [bshe_pkg::BYTE_W-1:0] shadow_data [MAX_DATA];
    logic [bshe_pkg::BYTE_W-1:0] shadow_par [PARITY_SLOTS];
    int                          shadow_cnt;
    int                          shadow_npos;
    logic                        shadow_ovf;

    int       gen_cnt;      // data count as the generator sees it
    int       fail_cnt;
    int       cyc;
    int       quiet_lo;
    int       quiet_hi;
    int       hold_idx;
    logic     hold_go;
    bit       in_take;      // beat accepted at the coming edge
    bit       out_take;
    t_code_rd out_snap;

    bit_sliced_hamming_encoder #(
        .MAX_DATA    (MAX_DATA),
        .PARITY_SLOTS(PARITY_SLOTS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_req_type   (i_in_req_type),
        .i_in_data_byte  (i_in_data_byte),
        .i_in_first_byte (i_in_first_byte),
        .i_in_read_pos   (i_in_read_pos),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_code_byte (o_out_code_byte),
        .o_out_code_len  (o_out_code_len),
        .o_out_bad_pos   (o_out_bad_pos),
        .o_out_overflowed(o_out_overflowed)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // smallest p >= 2 with p + n < 2^p, bounded by the slot count
    function automatic int parity_bytes(input int n);
        int p;
        p = 2;
        while (p < PARITY_SLOTS && p + n >= (1 << p)) begin
            p++;
        end
        return p;
    endfunction

    function automatic int gen_len();
        return gen_cnt + parity_bytes(gen_cnt);
    endfunction

    // Predictor: folds a load into the shadow codeword, or decodes a read.
    task automatic codeword_step(input logic req, input logic [bshe_pkg::BYTE_W-1:0] data,
                                 input logic first, input logic [bshe_pkg::LEN_W-1:0] pos,
                                 output bit has_res, output t_code_rd res);
        int p;
        int len;
        int posn;
        int lg;
        int j;
        has_res = 1'b0;
        res = '0;
        if (req == bshe_pkg::REQ_LOAD) begin
            if (first) begin
                for (int k = 0; k < PARITY_SLOTS; k++) begin
                    shadow_par[k] = '0;
                end
                shadow_cnt = 0;
                shadow_npos = 3;
                shadow_ovf = 1'b0;
            end
            if (shadow_cnt >= CODE_CAP) begin
                shadow_ovf = 1'b1;
            end else begin
                shadow_data[shadow_cnt] = data;
                for (int k = 0; k < PARITY_SLOTS; k++) begin
                    if ((shadow_npos >> k) & 1) begin
                        shadow_par[k] = shadow_par[k] ^ data;
                    end
                end
                shadow_cnt = shadow_cnt + 1;
                shadow_npos = shadow_npos + 1;
                // skip parity positions
                if ((shadow_npos & (shadow_npos - 1)) == 0) begin
                    shadow_npos = shadow_npos + 1;
                end
            end
        end else begin
            has_res = 1'b1;
            p = parity_bytes(shadow_cnt);
            len = shadow_cnt + p;
            res.len = bshe_pkg::LEN_W'(len);
            res.ovf = shadow_ovf;
            if (int'(pos) >= len) begin
                res.bad = 1'b1;
            end else begin
                posn = int'(pos) + 1;
                lg = 0;
                for (int t = posn; t > 1; t = t >> 1) begin
                    lg++;
                end
                if ((posn & (posn - 1)) == 0) begin
                    if (lg < p) begin
                        res.code = shadow_par[lg];
                    end
                end else begin
                    j = posn - 1 - (lg + 1);
                    if (j < shadow_cnt) begin
                        res.code = shadow_data[j];
                    end
                end
            end
        end
    endtask

    function automatic t_beat load_beat(input logic first);
        t_beat b;
        b = '0;
        b.req = bshe_pkg::REQ_LOAD;
        b.data = bshe_pkg::BYTE_W'($urandom_range(0, 255));
        b.first = first;
        b.pos = bshe_pkg::LEN_W'($urandom_range(0, 2047));  // ignored on loads
        return b;
    endfunction

    task automatic push_read(input int pos);
        t_beat b;
        b = '0;
        b.req = bshe_pkg::REQ_READ;
        b.data = bshe_pkg::BYTE_W'($urandom_range(0, 255));  // ignored on reads
        b.first = 1'($urandom_range(0, 1));
        b.pos = bshe_pkg::LEN_W'(pos);
        stim.push_back(b);
    endtask

    // Well-formed message: loads with a few reads mixed in, then a readback.
    task automatic push_message(input int n_loads, input bit fresh);
        for (int i = 0; i < n_loads; i++) begin
            stim.push_back(load_beat(fresh && i == 0));
            if (fresh && i == 0) begin
                gen_cnt = 0;
            end
            if (gen_cnt < CODE_CAP) begin
                gen_cnt++;
            end
            if ($urandom_range(0, 99) < 12) begin
                push_read($urandom_range(0, gen_len() - 1));
            end
        end
        repeat ($urandom_range(2, 6)) begin
            push_read($urandom_range(0, gen_len() - 1));
        end
        if ($urandom_range(0, 99) < 60) begin
            push_read($urandom_range(gen_len(), 2047));
        end
        if ($urandom_range(0, 99) < 10) begin
            push_read($urandom_range(0, 2047));
        end
    endtask

    task automatic push_random_part(input int n_items);
        int stop_at;
        int n;
        stop_at = stim.size() + n_items;
        while (stim.size() < stop_at) begin
            n = ($urandom_range(0, 99) < 8) ? $urandom_range(40, 150) : $urandom_range(1, 16);
            push_message(n, $urandom_range(0, 99) < 80);
        end
    endtask

    task automatic flag_mismatch(input string what, input int e, input int a);
        fail_cnt++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, e, a);
    endtask

    // Handshakes and results sampled mid-cycle, acted on at the next edge.
    always @(negedge i_clk) begin
        in_take = (i_in_valid === 1'b1) && (o_in_stall === 1'b0);
        out_take = (o_out_valid === 1'b1) && (i_out_stall === 1'b0);
        out_snap = '{o_out_code_byte, o_out_code_len, o_out_bad_pos, o_out_overflowed};
    end

    // Scoreboard: check the result beat first, then predict the accepted request.
    always @(posedge i_clk) begin
        t_code_rd want;
        t_code_rd pred;
        bit       has_res;
        if (!i_rst_n) begin
            for (int k = 0; k < PARITY_SLOTS; k++) begin
                shadow_par[k] = '0;
            end
            shadow_cnt = 0;
            shadow_npos = 3;
            shadow_ovf = 1'b0;
        end else begin
            if (out_take) begin
                if (pending_reads.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: result beat, expected none actual code %0d len %0d",
                             $time, out_snap.code, out_snap.len);
                end else begin
                    want = pending_reads.pop_front();
                    if (out_snap.code !== want.code) begin
                        flag_mismatch("code_byte", want.code, out_snap.code);
                    end
                    if (out_snap.len !== want.len) begin
                        flag_mismatch("code_len", want.len, out_snap.len);
                    end
                    if (out_snap.bad !== want.bad) begin
                        flag_mismatch("bad_pos", want.bad, out_snap.bad);
                    end
                    if (out_snap.ovf !== want.ovf) begin
                        flag_mismatch("overflowed", want.ovf, out_snap.ovf);
                    end
                end
            end
            if (in_take) begin
                codeword_step(i_in_req_type, i_in_data_byte, i_in_first_byte,
                              i_in_read_pos, has_res, pred);
                if (has_res) begin
                    pending_reads.push_back(cur_chk ? cur_typed : pred);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Receiver: random stall, then once a long hold-off so the output register
    // fills and reads back up the request side, followed by a stall-free stretch.
    initial begin
        int  hold_left;
        int  quiet_left;
        bit  hold_seen;
        hold_left = 0;
        quiet_left = 0;
        hold_seen = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (quiet_left > 0) begin
                i_out_stall <= 1'b0;
                quiet_left--;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < 13);
            end
            if (hold_go === 1'b1 && !hold_seen) begin
                hold_seen = 1'b1;
                hold_left = HOLD_CYCLES;
                quiet_left = QUIET_CYCLES;
            end
        end
    end

    // Sender and end of run.
    initial begin
        int    idx;
        bit    offering;
        bit    idle;
        int    part_b;
        t_beat b;
        i_in_valid      <= 1'b0;
        i_in_req_type   <= bshe_pkg::REQ_LOAD;
        i_in_data_byte  <= '0;
        i_in_first_byte <= 1'b0;
        i_in_read_pos   <= '0;
        cur_chk         <= 1'b0;
        cur_typed       <= '0;
        hold_go         <= 1'b0;
        gen_cnt = 0;

        foreach (DIR_TAB[i]) begin
            stim.push_back(DIR_TAB[i]);
        end
        // generator tracks the directed message: two bytes loaded
        gen_cnt = 2;
        quiet_lo = stim.size() + 100;
        quiet_hi = stim.size() + 250;
        push_random_part(320);
        // message past capacity: drops set the sticky flag; parity slot ten in use
        push_message(CODE_CAP + 6, 1'b1);
        repeat (30) begin
            push_read($urandom_range(0, gen_len() - 1));
        end
        push_read(1023);
        push_read(1034);
        push_read(1035);
        part_b = stim.size();
        hold_idx = part_b + 40;
        push_random_part(330);

        repeat (7) @(posedge i_clk);
        idx = 0;
        offering = 1'b0;
        while (1) begin
            if (offering && in_take) begin
                idx++;
                offering = 1'b0;
            end
            if (!offering && idx < stim.size()) begin
                idle = !(idx >= quiet_lo && idx < quiet_hi) && ($urandom_range(0, 99) < 13);
                if (!idle) begin
                    b = stim[idx];
                    i_in_req_type   <= b.req;
                    i_in_data_byte  <= b.data;
                    i_in_first_byte <= b.first;
                    i_in_read_pos   <= b.pos;
                    cur_chk         <= b.chk;
                    cur_typed       <= '{b.e_code, b.e_len, b.e_bad, b.e_ovf};
                    offering = 1'b1;
                    if (idx == hold_idx) begin
                        hold_go <= 1'b1;
                    end
                end
            end
            i_in_valid <= offering;
            if (!offering && idx >= stim.size()) begin
                break;
            end
            @(posedge i_clk);
        end

        while (pending_reads.size() != 0) begin
            @(posedge i_clk);
        end
        // leave room for a stray beat
        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

>>> bit_sliced_hamming_encoder.f
+incdir+hw/rtl
hw/rtl/bshe_pkg.sv
hw/rtl/bshe_locate.sv
hw/rtl/bit_sliced_hamming_encoder.sv
verif/tb.sv
